>>> rtl/websocket_frame_composer_defines.svh
// Assertion macros for the checker of the frame composer.
`ifndef WEBSOCKET_FRAME_COMPOSER_DEFINES_SVH
`define WEBSOCKET_FRAME_COMPOSER_DEFINES_SVH

// Same-cycle implication, inactive while in reset.
`define WSFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, inactive while in reset.
`define WSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define WSFC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/wsfc_pkg.sv
// Shared types and constants of the WebSocket frame composer.
`default_nettype none
package wsfc_pkg;

  localparam int LEN_W      = 63;
  localparam int KEY_W      = 32;
  localparam int OPC_W      = 4;
  localparam int BYTE_W     = 8;
  localparam int STEP_W     = 4;   // header has at most 14 bytes
  localparam int FIFO_DEPTH = 4;

  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [BYTE_W-1:0] FIN_BIT    = 8'h80;
  localparam logic [6:0]        LEN7_MAX   = 7'd125;
  localparam logic [15:0]       LEN16_MAX  = 16'hFFFF;
  localparam logic [6:0]        LEN_CODE16 = 7'd126;
  localparam logic [6:0]        LEN_CODE64 = 7'd127;

  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_DATA,
    CMD_ERR
  } cmd_kind_t;

  typedef enum logic [1:0] {
    LEN_7,
    LEN_16,
    LEN_64
  } len_cls_t;

  // One queued command from front to back end.
  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_W-1:0]  data;      // finished payload byte
    logic               fend;      // payload byte closes the frame
    logic [OPC_W-1:0]   opcode;
    logic [LEN_W-1:0]   len;
    logic [KEY_W-1:0]   key;
    logic               mask;
    len_cls_t           len_cls;
    logic               zero_len;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/wsfc_queue.sv
// Small register FIFO of commands between front and back end.
`default_nettype none
module wsfc_queue #(
  parameter int DEPTH = wsfc_pkg::FIFO_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wsfc_pkg::cmd_t wr_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output wsfc_pkg::cmd_t      rd_cmd
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  wsfc_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

>>> rtl/wsfc_front.sv
// Front end: accepts items, tracks frame state and queues commands.
`default_nettype none
module wsfc_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_kind,
  input  wire logic [wsfc_pkg::OPC_W-1:0]     in_opcode,
  input  wire logic [wsfc_pkg::LEN_W-1:0]     in_payload_length,
  input  wire logic [wsfc_pkg::KEY_W-1:0]     in_mask_key,
  input  wire logic [wsfc_pkg::BYTE_W-1:0]    in_data_byte,
  input  wire logic                           q_full,
  output logic                                q_push,
  output wsfc_pkg::cmd_t                      q_cmd
);

  logic                          mask_en_r;
  logic                          frame_open_r, frame_open_nxt;
  logic [wsfc_pkg::LEN_W-1:0]    remain_r, remain_nxt;
  logic [wsfc_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic                          accept;
  logic [wsfc_pkg::BYTE_W-1:0]   key_byte;
  logic                          last_byte;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign q_push    = accept;
  // byte 0 of the key sits in bits 31..24
  assign key_byte  = key_r[{~phase_r, 3'b000} +: 8];
  assign last_byte = (remain_r == wsfc_pkg::LEN_W'(1));

  always_comb begin
    frame_open_nxt  = frame_open_r;
    remain_nxt      = remain_r;
    key_nxt         = key_r;
    phase_nxt       = phase_r;
    q_cmd           = '0;
    q_cmd.kind      = wsfc_pkg::CMD_ERR;
    q_cmd.opcode    = in_opcode;
    q_cmd.len       = in_payload_length;
    q_cmd.key       = in_mask_key;
    q_cmd.mask      = mask_en_r;
    q_cmd.zero_len  = (in_payload_length == '0);
    if (in_payload_length <= wsfc_pkg::LEN_W'(wsfc_pkg::LEN7_MAX)) begin
      q_cmd.len_cls = wsfc_pkg::LEN_7;
    end else if (in_payload_length <= wsfc_pkg::LEN_W'(wsfc_pkg::LEN16_MAX)) begin
      q_cmd.len_cls = wsfc_pkg::LEN_16;
    end else begin
      q_cmd.len_cls = wsfc_pkg::LEN_64;
    end

    if (in_kind == wsfc_pkg::KIND_HDR) begin
      if (!frame_open_r) begin
        q_cmd.kind     = wsfc_pkg::CMD_HDR;
        frame_open_nxt = (in_payload_length != '0);
        remain_nxt     = in_payload_length;
        key_nxt        = mask_en_r ? in_mask_key : '0;
        phase_nxt      = '0;
      end
    end else begin
      if (frame_open_r) begin
        q_cmd.kind     = wsfc_pkg::CMD_DATA;
        q_cmd.data     = in_data_byte ^ key_byte;
        q_cmd.fend     = last_byte;
        remain_nxt     = remain_r - 1'b1;
        phase_nxt      = phase_r + 1'b1;
        frame_open_nxt = !last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_en_r    <= 1'b0;
      frame_open_r <= 1'b0;
      remain_r     <= '0;
      key_r        <= '0;
      phase_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        mask_en_r <= cfg_wr_data;
      end
      if (accept) begin
        frame_open_r <= frame_open_nxt;
        remain_r     <= remain_nxt;
        key_r        <= key_nxt;
        phase_r      <= phase_nxt;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/wsfc_back.sv
// Back end: expands queued commands into wire bytes, one per cycle while the output is not stalled.
`default_nettype none
module wsfc_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire wsfc_pkg::cmd_t                q_cmd,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wsfc_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_frame_end,
  output logic                               out_run_end,
  output logic                               out_error
);

  logic [wsfc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        out_valid_r;
  logic [wsfc_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic                        fend_r, fend_nxt;
  logic                        rend_r, rend_nxt;
  logic                        err_r, err_nxt;
  logic                        adv, emit, last;
  logic [wsfc_pkg::STEP_W-1:0] ext_cnt, hdr_last, sub;
  logic [wsfc_pkg::STEP_W-1:0] len_idx, key_idx;
  logic [6:0]                  len_code;
  logic [wsfc_pkg::LEN_W:0]    len64;

  assign adv   = !out_valid_r || !out_stall;
  assign emit  = !q_empty && adv;
  assign q_pop = emit && last;
  assign len64 = {1'b0, q_cmd.len};

  always_comb begin
    case (q_cmd.len_cls)
      wsfc_pkg::LEN_7: begin
        ext_cnt  = 4'd0;
        len_code = q_cmd.len[6:0];
      end
      wsfc_pkg::LEN_16: begin
        ext_cnt  = 4'd2;
        len_code = wsfc_pkg::LEN_CODE16;
      end
      wsfc_pkg::LEN_64: begin
        ext_cnt  = 4'd8;
        len_code = wsfc_pkg::LEN_CODE64;
      end
      default: begin
        ext_cnt  = 4'd8;
        len_code = wsfc_pkg::LEN_CODE64;
      end
    endcase
    hdr_last = 4'd1 + ext_cnt + (q_cmd.mask ? 4'd4 : 4'd0);
    sub      = step_r - 4'd2;
    len_idx  = ext_cnt - 4'd1 - sub;  // big-endian length bytes
    key_idx  = sub - ext_cnt;

    last     = 1'b1;
    byte_nxt = '0;
    fend_nxt = 1'b0;
    rend_nxt = 1'b1;
    err_nxt  = 1'b0;
    case (q_cmd.kind)
      wsfc_pkg::CMD_HDR: begin
        last     = (step_r == hdr_last);
        rend_nxt = last;
        fend_nxt = last && q_cmd.zero_len;
        if (step_r == 4'd0) begin
          byte_nxt = wsfc_pkg::FIN_BIT | {4'b0000, q_cmd.opcode};
        end else if (step_r == 4'd1) begin
          byte_nxt = {q_cmd.mask, len_code};
        end else if (sub < ext_cnt) begin
          byte_nxt = len64[{len_idx[2:0], 3'b000} +: 8];
        end else begin
          byte_nxt = q_cmd.key[{~key_idx[1:0], 3'b000} +: 8];
        end
      end
      wsfc_pkg::CMD_DATA: begin
        byte_nxt = q_cmd.data;
        fend_nxt = q_cmd.fend;
      end
      wsfc_pkg::CMD_ERR: begin
        err_nxt = 1'b1;
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase

    step_nxt = step_r;
    if (q_pop) begin
      step_nxt = '0;
    end else if (emit) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (adv) begin
        out_valid_r <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= byte_nxt;
      fend_r <= fend_nxt;
      rend_r <= rend_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_frame_end = fend_r;
  assign out_run_end   = rend_r;
  assign out_error     = err_r;

endmodule
`default_nettype wire

>>> rtl/websocket_frame_composer.sv
// Top level of the WebSocket frame composer: front end, command queue, back end.
// Flow: an accepted beat is written into the command queue, and its first byte is then loaded
//   into the output register when the back end is idle and the output is not stalled.
// Throughput: one payload beat per cycle in and out while unstalled; errors give one beat and
//   a header beat 2 to 14 output beats, one per cycle, set by the back end's single byte lane.
// Reset: synchronous active-low rst_n clears frame state, mask enable, queue pointers
//   and output valid; payload registers keep their value.
`default_nettype none
module websocket_frame_composer #(
  parameter int FIFO_DEPTH = wsfc_pkg::FIFO_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration: mask_enable
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  // input beats
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [wsfc_pkg::OPC_W-1:0]    in_opcode,
  input  wire logic [wsfc_pkg::LEN_W-1:0]    in_payload_length,
  input  wire logic [wsfc_pkg::KEY_W-1:0]    in_mask_key,
  input  wire logic [wsfc_pkg::BYTE_W-1:0]   in_data_byte,
  // output beats
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wsfc_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_frame_end,
  output logic                               out_run_end,
  output logic                               out_error
);

  wsfc_pkg::cmd_t push_cmd;
  wsfc_pkg::cmd_t head_cmd;
  logic           q_push, q_full, q_pop, q_empty;

  // Front: frame state lives here, so it runs ahead of the byte expansion.
  wsfc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_opcode         (in_opcode),
    .in_payload_length (in_payload_length),
    .in_mask_key       (in_mask_key),
    .in_data_byte      (in_data_byte),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_cmd             (push_cmd)
  );

  // Command queue decouples the two stall domains.
  wsfc_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (push_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (head_cmd)
  );

  // Back: header sequencer plus output register.
  wsfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (head_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_run_end   (out_run_end),
    .out_error     (out_error)
  );

endmodule
`default_nettype wire

>>> rtl/wsfc_checker.sv
// Port-level checker for the frame composer and its bind.
`default_nettype none
`include "websocket_frame_composer_defines.svh"
module wsfc_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [wsfc_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                          out_frame_end,
  input wire logic                          out_run_end,
  input wire logic                          out_error
);

  // error beats are zero, single, and never close a frame
  `WSFC_ASSERT_NOW(a_err_beat, out_valid && out_error, (out_byte == 8'h00) && !out_frame_end && out_run_end, "bad error beat")

  // the closing byte of a frame is always the last beat of its item
  `WSFC_ASSERT_NOW(a_fend_rend, out_valid && out_frame_end, out_run_end, "frame end without run end")

  // a stalled output beat holds
  `WSFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_frame_end) && $stable(out_run_end) && $stable(out_error), "stalled output changed")

  // nothing comes out right after reset
  `WSFC_ASSERT_ALWAYS(a_rst_quiet, !rst_n, !out_valid, "output valid after reset")

endmodule

bind websocket_frame_composer wsfc_checker u_wsfc_checker (.*);
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for websocket_frame_composer: frame byte predictor and random driving.
`timescale 1ns / 1ps

// One input beat, in port order.
typedef struct packed {
  logic                          kind;
  logic [wsfc_pkg::OPC_W-1:0]    opcode;
  logic [wsfc_pkg::LEN_W-1:0]    len;
  logic [wsfc_pkg::KEY_W-1:0]    key;
  logic [wsfc_pkg::BYTE_W-1:0]   data;
} frame_item_t;

// One output beat as it should appear on the wire.
typedef struct packed {
  logic [wsfc_pkg::BYTE_W-1:0] b;
  logic                        fend;
  logic                        rend;
  logic                        err;
} wire_byte_t;

// Tracks the frame state of the composer and the wire bytes still owed by it.
class frame_wire_model;
  logic                        mask_en;
  logic                        frame_open;
  logic [wsfc_pkg::LEN_W-1:0]  owed;
  logic [wsfc_pkg::KEY_W-1:0]  key_reg;
  logic [1:0]                  phase;
  wire_byte_t                  bytes_due[$];
  int                          mismatches;

  function new();
    mask_en    = 1'b0;
    frame_open = 1'b0;
    owed       = '0;
    key_reg    = '0;
    phase      = 2'd0;
    mismatches = 0;
  endfunction

  function void due(logic [7:0] b, logic fend, logic rend, logic err);
    wire_byte_t w;
    w.b    = b;
    w.fend = fend;
    w.rend = rend;
    w.err  = err;
    bytes_due.push_back(w);
  endfunction

  // Expand one accepted input beat into the bytes it must produce.
  function void take_item(frame_item_t it);
    logic [7:0]  hdr[$];
    logic [63:0] len64;
    logic [7:0]  kb;
    int          last;
    if (it.kind == wsfc_pkg::KIND_HDR) begin
      // a second header inside an open frame is rejected, state untouched
      if (frame_open) begin
        due(8'h00, 1'b0, 1'b1, 1'b1);
        return;
      end
      len64 = {1'b0, it.len};
      hdr.push_back(wsfc_pkg::FIN_BIT | 8'(it.opcode));
      if (it.len <= 63'(wsfc_pkg::LEN7_MAX)) begin
        hdr.push_back({mask_en, it.len[6:0]});
      end else if (it.len <= 63'(wsfc_pkg::LEN16_MAX)) begin
        hdr.push_back({mask_en, wsfc_pkg::LEN_CODE16});
        hdr.push_back(it.len[15:8]);
        hdr.push_back(it.len[7:0]);
      end else begin
        hdr.push_back({mask_en, wsfc_pkg::LEN_CODE64});
        for (int i = 7; i >= 0; i--) hdr.push_back(len64[8*i +: 8]);
      end
      if (mask_en) begin
        for (int i = 3; i >= 0; i--) hdr.push_back(it.key[8*i +: 8]);
      end
      last = hdr.size() - 1;
      // an empty frame ends on its last header byte
      foreach (hdr[i]) due(hdr[i], (i == last) && (it.len == 0), i == last, 1'b0);
      frame_open = (it.len != 0);
      owed       = it.len;
      key_reg    = mask_en ? it.key : '0;
      phase      = 2'd0;
    end else begin
      if (!frame_open) begin
        due(8'h00, 1'b0, 1'b1, 1'b1);
        return;
      end
      kb   = key_reg[8*(3 - phase) +: 8];
      owed = owed - 1'b1;
      due(it.data ^ kb, owed == 0, 1'b1, 1'b0);
      phase = phase + 2'd1;
      if (owed == 0) frame_open = 1'b0;
    end
  endfunction

  // Compare one accepted output beat with the oldest owed byte.
  function void check_wire_byte(logic [7:0] b, logic fend, logic rend, logic err);
    wire_byte_t w;
    if (bytes_due.size() == 0) begin
      $error("output beat with nothing owed: out_byte %02h", b);
      mismatches++;
      return;
    end
    w = bytes_due.pop_front();
    if (b !== w.b) begin
      $error("out_byte: expected %02h, got %02h", w.b, b);
      mismatches++;
    end
    if (fend !== w.fend) begin
      $error("frame_end: expected %0b, got %0b", w.fend, fend);
      mismatches++;
    end
    if (rend !== w.rend) begin
      $error("run_end: expected %0b, got %0b", w.rend, rend);
      mismatches++;
    end
    if (err !== w.err) begin
      $error("error: expected %0b, got %0b", w.err, err);
      mismatches++;
    end
  endfunction
endclass

module tb;
  // Slowest legal run: about 200 beats, each expanding to at most 14 bytes that each
  // may wait out a random receiver stall, plus input gaps: well within CYCLE_LIMIT.
  localparam int CYCLE_LIMIT = 200_000;
  localparam int MAX_WAIT    = 12;
  localparam int RAND_ITEMS  = 24;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic                          cfg_wr_data = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_kind = wsfc_pkg::KIND_HDR;
  logic [wsfc_pkg::OPC_W-1:0]    in_opcode = '0;
  logic [wsfc_pkg::LEN_W-1:0]    in_payload_length = '0;
  logic [wsfc_pkg::KEY_W-1:0]    in_mask_key = '0;
  logic [wsfc_pkg::BYTE_W-1:0]   in_data_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [wsfc_pkg::BYTE_W-1:0]   out_byte;
  logic                          out_frame_end;
  logic                          out_run_end;
  logic                          out_error;

  frame_wire_model sb;
  bit              tx_idle_on = 1'b1;   // sender draws gaps between beats
  bit              rx_stall_on = 1'b1;  // receiver draws stalls after beats
  int              stall_left = 0;
  int              items_sent = 0;
  int              cycles = 0;

  websocket_frame_composer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_opcode         (in_opcode),
    .in_payload_length (in_payload_length),
    .in_mask_key       (in_mask_key),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end),
    .out_run_end       (out_run_end),
    .out_error         (out_error)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake or a lost byte ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Input monitor: every accepted beat feeds the predictor at its acceptance edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.take_item({in_kind, in_opcode, in_payload_length, in_mask_key, in_data_byte});
  end

  // Output side: check each accepted beat, then draw a random stall before the next.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_wire_byte(out_byte, out_frame_end, out_run_end, out_error);
      stall_left = rx_stall_on ? $urandom_range(0, MAX_WAIT) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Random content for every field; callers overwrite the fields that matter.
  function automatic frame_item_t noise_item();
    frame_item_t it;
    it.kind   = 1'($urandom_range(0, 1));
    it.opcode = 4'($urandom);
    it.len    = 63'({$urandom, $urandom});
    it.key    = $urandom;
    it.data   = 8'($urandom);
    return it;
  endfunction

  // Present one beat and hold it until accepted. Returns at the acceptance edge.
  task automatic push_item(frame_item_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= it.kind;
    in_opcode         <= it.opcode;
    in_payload_length <= it.len;
    in_mask_key       <= it.key;
    in_data_byte      <= it.data;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_hdr(logic [3:0] op, logic [62:0] len, logic [31:0] key);
    frame_item_t it;
    it        = noise_item();
    it.kind   = wsfc_pkg::KIND_HDR;
    it.opcode = op;
    it.len    = len;
    it.key    = key;
    push_item(it);
  endtask

  task automatic send_byte(logic [7:0] d);
    frame_item_t it;
    it      = noise_item();
    it.kind = wsfc_pkg::KIND_DATA;
    it.data = d;
    push_item(it);
  endtask

  // Whole frame with random opcode, key and payload.
  task automatic send_frame(int len);
    send_hdr(4'($urandom), 63'(len), $urandom);
    for (int k = 0; k < len; k++) send_byte(8'($urandom));
  endtask

  // Sender goes quiet until every owed byte has been seen. The first edge lets
  // the monitor record the beat accepted at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.bytes_due.size() != 0) @(posedge clk);
  endtask

  // Only called with the block drained.
  task automatic set_mask(bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.mask_en = v;
    cfg_wr_en  <= 1'b0;
  endtask

  initial begin
    int len;
    int r;
    int err_at;
    int stop_at;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: extremes and out-of-order cases ----
    send_byte(8'hFF);                        // payload with no frame open
    send_hdr(4'hF, 63'd0, 32'h1234_5678);    // empty frame, unmasked
    drain();
    set_mask(1'b1);
    send_hdr(4'h0, 63'd0, 32'hFFFF_FFFF);    // empty frame ends on last key byte
    send_hdr(4'h2, 63'd3, 32'hA1B2_C3D4);
    send_byte(8'h00);
    send_hdr(4'h9, 63'd1, 32'h0BAD_F00D);    // header inside open frame
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h77);                        // stray byte after frame closed
    send_hdr(4'hA, 63'd1, 32'h0000_0000);    // masked with an all-zero key
    send_byte(8'hC3);
    // mask flipped mid-frame: the open frame keeps its latched key
    send_hdr(4'h1, 63'd6, 32'h5AC3_9E17);
    send_byte(8'h11);
    send_byte(8'h22);
    drain();
    set_mask(1'b0);
    for (int k = 0; k < 4; k++) send_byte(8'($urandom));
    send_hdr(4'h8, 63'd2, 32'hDEAD_BEEF);    // next frame sees the new setting
    send_byte(8'h00);
    send_byte(8'hFF);

    // ---- smallest 16-bit length, masked, streamed back to back ----
    drain();
    set_mask(1'b1);
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    send_frame(126);
    drain();

    // ---- random frames with some noise ----
    stop_at = items_sent + RAND_ITEMS;
    while (items_sent < stop_at) begin
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        drain();
        set_mask(1'($urandom_range(0, 1)));
      end
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(0, 6);
      else        len = $urandom_range(7, 20);
      err_at = ($urandom_range(0, 9) == 0 && len > 0) ? $urandom_range(0, len - 1) : -1;
      send_hdr(4'($urandom), 63'(len), $urandom);
      for (int k = 0; k < len; k++) begin
        if (k == err_at) send_hdr(4'($urandom), 63'({$urandom, $urandom}), $urandom);
        send_byte(8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
    end

    // ---- final phase: largest length leaves the frame open for good ----
    drain();
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    set_mask(1'b1);
    send_hdr(4'($urandom), {63{1'b1}}, $urandom);
    for (int k = 0; k < 12; k++) begin
      if ($urandom_range(0, 4) < 3) send_byte(8'($urandom));
      else send_hdr(4'($urandom), 63'({$urandom, $urandom}), $urandom);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/wsfc_pkg.sv
rtl/wsfc_queue.sv
rtl/wsfc_front.sv
rtl/wsfc_back.sv
rtl/websocket_frame_composer.sv
rtl/wsfc_checker.sv
dv/tb.sv
